// ===== rtl/scp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session client package
// Widths, event codes, register indexes and reset values of the session
// client protocol block.
// ----------------------------------------------------------------------------
package scp_pkg;

    // Field widths.
    localparam int unsigned FUNC_W     = 3;
    localparam int unsigned MAGIC_W    = 16;
    localparam int unsigned SESSION_W  = 32;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned CLOCK_W    = 64;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned STATE_W    = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Event codes carried by an input beat.
    localparam logic [FUNC_W-1:0] FUNC_START    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PACKET   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LINE     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_HELLO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_DATA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ALIVE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_GOODBYE = 3'd6;

    // Register reset values.
    localparam logic [TICK_W-1:0] TIMEOUT_RESET      = 16'd5;
    localparam logic [CODE_W-1:0] CODE_HELLO_RESET   = 8'd0;
    localparam logic [CODE_W-1:0] CODE_DATA_RESET    = 8'd1;
    localparam logic [CODE_W-1:0] CODE_ALIVE_RESET   = 8'd2;
    localparam logic [CODE_W-1:0] CODE_GOODBYE_RESET = 8'd3;

    // Largest value of the tick counter; it saturates there.
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

endpackage

// ===== rtl/session_client_protocol_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session client protocol state machine
// Client side of a datagram session: takes start, packet, line read, line
// dispatch and tick events and says which command to send with its stamps.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake             | Beat contents
//  ---------+-----------+-----------------------+-------------------------------
//  input    | in        | in_valid / in_stall   | func, too_short, rx_* header,
//           |           |                       | line_is_end
//  result   | out       | out_valid / out_stall | send_*, session_state,
//           |           |                       | line_taken, packet_accepted
//  config   | in        | cfg_write             | cfg_index, cfg_data
//
// One event is taken per cycle unless a stalled result holds the input register.
// An event is captured in the input register and evaluated against the session
// state once the result register is free; its result beat is then captured in
// the result register. The path is bounded by the 64-bit clock compare and
// increment. Reset leaves the session closed with all counters at zero and the
// registers at their default values. A stalled result holds in the output
// register while one more event waits in the input register.

module session_client_protocol_fsm
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [scp_pkg::FUNC_W-1:0]          func,
    input  logic                                too_short,
    input  logic [scp_pkg::MAGIC_W-1:0]         rx_magic,
    input  logic [scp_pkg::SESSION_W-1:0]       rx_session,
    input  logic [scp_pkg::CODE_W-1:0]          rx_command,
    input  logic [scp_pkg::CLOCK_W-1:0]         rx_clock,
    input  logic                                line_is_end,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                send_valid,
    output logic [scp_pkg::CODE_W-1:0]          send_command,
    output logic [scp_pkg::SEQ_W-1:0]           send_sequence,
    output logic [scp_pkg::CLOCK_W-1:0]         send_clock,
    output logic [scp_pkg::STATE_W-1:0]         session_state,
    output logic                                line_taken,
    output logic                                packet_accepted,

    input  logic                                cfg_write,
    input  logic [scp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [scp_pkg::STATE_W-1:0] {
        MODE_HELLO_WAIT  = 3'd0,
        MODE_READY       = 3'd1,
        MODE_READY_TIMER = 3'd2,
        MODE_CLOSING     = 3'd3,
        MODE_CLOSED      = 3'd4
    } mode_t;

    // Configuration registers.
    logic [scp_pkg::SESSION_W-1:0] session_number_reg;
    logic [scp_pkg::MAGIC_W-1:0]   magic_value_reg;
    logic [scp_pkg::TICK_W-1:0]    timeout_ticks_reg;
    logic [scp_pkg::CODE_W-1:0]    code_hello_reg;
    logic [scp_pkg::CODE_W-1:0]    code_data_reg;
    logic [scp_pkg::CODE_W-1:0]    code_alive_reg;
    logic [scp_pkg::CODE_W-1:0]    code_goodbye_reg;

    // Input register.
    logic                          in_valid_reg;
    logic [scp_pkg::FUNC_W-1:0]    func_reg;
    logic                          too_short_reg;
    logic [scp_pkg::MAGIC_W-1:0]   rx_magic_reg;
    logic [scp_pkg::SESSION_W-1:0] rx_session_reg;
    logic [scp_pkg::CODE_W-1:0]    rx_command_reg;
    logic [scp_pkg::CLOCK_W-1:0]   rx_clock_reg;
    logic                          line_is_end_reg;

    // Session state.
    mode_t                         mode_reg;
    mode_t                         mode_next;
    logic                          timer_running_reg;
    logic                          timer_running_next;
    logic [scp_pkg::TICK_W-1:0]    elapsed_ticks_reg;
    logic [scp_pkg::TICK_W-1:0]    elapsed_ticks_next;
    logic [scp_pkg::SEQ_W-1:0]     next_sequence_reg;
    logic [scp_pkg::SEQ_W-1:0]     next_sequence_next;
    logic [scp_pkg::CLOCK_W-1:0]   lamport_clock_reg;
    logic [scp_pkg::CLOCK_W-1:0]   lamport_clock_next;

    // Result register.
    logic                          out_valid_reg;
    logic                          send_valid_reg;
    logic                          send_valid_next;
    logic [scp_pkg::CODE_W-1:0]    send_command_reg;
    logic [scp_pkg::CODE_W-1:0]    send_command_next;
    logic [scp_pkg::SEQ_W-1:0]     send_sequence_reg;
    logic [scp_pkg::SEQ_W-1:0]     send_sequence_next;
    logic [scp_pkg::CLOCK_W-1:0]   send_clock_reg;
    logic [scp_pkg::CLOCK_W-1:0]   send_clock_next;
    mode_t                         session_state_reg;
    logic                          line_taken_reg;
    logic                          line_taken_next;
    logic                          packet_accepted_reg;
    logic                          packet_accepted_next;

    // Handshake control.
    logic                          in_accept;
    logic                          out_free;
    logic                          evaluate;

    // Evaluation helpers.
    logic                          packet_ok;
    logic                          bump_clock;
    logic [scp_pkg::CLOCK_W-1:0]   clock_base;
    logic [scp_pkg::CLOCK_W-1:0]   clock_bumped;
    logic [scp_pkg::TICK_W-1:0]    elapsed_sat;
    logic                          do_send;
    logic [scp_pkg::CODE_W-1:0]    send_code;

    // The result register frees when empty or when its beat is taken.
    assign out_free  = !out_valid_reg || !out_stall;
    assign evaluate  = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Header checks and the shared clock increment.
    assign packet_ok    = !too_short_reg && (rx_magic_reg == magic_value_reg)
                          && (rx_session_reg == session_number_reg);
    assign clock_base   = (func_reg == scp_pkg::FUNC_PACKET
                           && rx_clock_reg > lamport_clock_reg)
                          ? rx_clock_reg : lamport_clock_reg;
    assign clock_bumped = clock_base + 1'b1;
    assign elapsed_sat  = (elapsed_ticks_reg == scp_pkg::TICK_MAX)
                          ? elapsed_ticks_reg : elapsed_ticks_reg + 1'b1;

    // Event evaluation against the current session state.
    always_comb
    begin
        mode_next            = mode_reg;
        timer_running_next   = timer_running_reg;
        elapsed_ticks_next   = elapsed_ticks_reg;
        packet_accepted_next = 1'b0;
        line_taken_next      = 1'b0;
        bump_clock           = 1'b0;
        do_send              = 1'b0;
        send_code            = code_data_reg;

        if (func_reg == scp_pkg::FUNC_START)
        begin
            if (mode_reg == MODE_CLOSED)
            begin
                do_send            = 1'b1;
                send_code          = code_hello_reg;
                mode_next          = MODE_HELLO_WAIT;
                timer_running_next = 1'b1;
                elapsed_ticks_next = '0;
            end
        end
        else if (mode_reg != MODE_CLOSED)
        begin
            unique case (func_reg)
                scp_pkg::FUNC_PACKET:
                begin
                    if (packet_ok)
                    begin
                        packet_accepted_next = 1'b1;
                        bump_clock           = 1'b1;
                        if (rx_command_reg == code_goodbye_reg)
                        begin
                            mode_next          = MODE_CLOSED;
                            timer_running_next = 1'b0;
                            elapsed_ticks_next = '0;
                        end
                        else if ((mode_reg == MODE_HELLO_WAIT
                                  && rx_command_reg == code_hello_reg)
                                 || (mode_reg == MODE_READY_TIMER
                                     && rx_command_reg == code_alive_reg))
                        begin
                            mode_next          = MODE_READY;
                            timer_running_next = 1'b0;
                            elapsed_ticks_next = '0;
                        end
                    end
                end
                scp_pkg::FUNC_LINE:
                begin
                    bump_clock = 1'b1;
                end
                scp_pkg::FUNC_DISPATCH:
                begin
                    if (mode_reg == MODE_READY || mode_reg == MODE_READY_TIMER)
                    begin
                        line_taken_next    = 1'b1;
                        do_send            = 1'b1;
                        timer_running_next = 1'b1;
                        elapsed_ticks_next = '0;
                        if (line_is_end_reg)
                        begin
                            send_code = code_goodbye_reg;
                            mode_next = MODE_CLOSING;
                        end
                        else
                        begin
                            send_code = code_data_reg;
                            mode_next = MODE_READY_TIMER;
                        end
                    end
                end
                scp_pkg::FUNC_TICK:
                begin
                    if (timer_running_reg)
                    begin
                        elapsed_ticks_next = elapsed_sat;
                        if (elapsed_sat >= timeout_ticks_reg)
                        begin
                            elapsed_ticks_next = '0;
                            if (mode_reg == MODE_CLOSING)
                            begin
                                mode_next          = MODE_CLOSED;
                                timer_running_next = 1'b0;
                            end
                            else
                            begin
                                // Timeout in an open state starts the close.
                                do_send            = 1'b1;
                                send_code          = code_goodbye_reg;
                                mode_next          = MODE_CLOSING;
                                timer_running_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    // Unused event codes leave the state alone.
                end
            endcase
        end

        // Stamps: a send takes the incremented clock and the current sequence.
        lamport_clock_next = (bump_clock || do_send) ? clock_bumped
                                                     : lamport_clock_reg;
        next_sequence_next = do_send ? next_sequence_reg + 1'b1
                                     : next_sequence_reg;
        send_valid_next    = do_send;
        send_command_next  = do_send ? send_code : '0;
        send_sequence_next = do_send ? next_sequence_reg : '0;
        send_clock_next    = do_send ? clock_bumped : '0;
    end

    // Configuration, input register, session state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_number_reg  <= '0;
            magic_value_reg     <= '0;
            timeout_ticks_reg   <= scp_pkg::TIMEOUT_RESET;
            code_hello_reg      <= scp_pkg::CODE_HELLO_RESET;
            code_data_reg       <= scp_pkg::CODE_DATA_RESET;
            code_alive_reg      <= scp_pkg::CODE_ALIVE_RESET;
            code_goodbye_reg    <= scp_pkg::CODE_GOODBYE_RESET;
            in_valid_reg        <= 1'b0;
            func_reg            <= '0;
            too_short_reg       <= 1'b0;
            rx_magic_reg        <= '0;
            rx_session_reg      <= '0;
            rx_command_reg      <= '0;
            rx_clock_reg        <= '0;
            line_is_end_reg     <= 1'b0;
            mode_reg            <= MODE_CLOSED;
            timer_running_reg   <= 1'b0;
            elapsed_ticks_reg   <= '0;
            next_sequence_reg   <= '0;
            lamport_clock_reg   <= '0;
            out_valid_reg       <= 1'b0;
            send_valid_reg      <= 1'b0;
            send_command_reg    <= '0;
            send_sequence_reg   <= '0;
            send_clock_reg      <= '0;
            session_state_reg   <= MODE_CLOSED;
            line_taken_reg      <= 1'b0;
            packet_accepted_reg <= 1'b0;
        end
        else
        begin
            // Register writes.
            if (cfg_write)
            begin
                unique case (cfg_index)
                    scp_pkg::CFG_SESSION:      session_number_reg <= cfg_data;
                    scp_pkg::CFG_MAGIC:        magic_value_reg <= cfg_data[scp_pkg::MAGIC_W-1:0];
                    scp_pkg::CFG_TIMEOUT:      timeout_ticks_reg <= cfg_data[scp_pkg::TICK_W-1:0];
                    scp_pkg::CFG_CODE_HELLO:   code_hello_reg <= cfg_data[scp_pkg::CODE_W-1:0];
                    scp_pkg::CFG_CODE_DATA:    code_data_reg <= cfg_data[scp_pkg::CODE_W-1:0];
                    scp_pkg::CFG_CODE_ALIVE:   code_alive_reg <= cfg_data[scp_pkg::CODE_W-1:0];
                    scp_pkg::CFG_CODE_GOODBYE: code_goodbye_reg <= cfg_data[scp_pkg::CODE_W-1:0];
                    default:
                    begin
                        // Writes beyond the register list are dropped.
                    end
                endcase
            end

            // Input beat capture.
            if (in_accept)
            begin
                in_valid_reg    <= 1'b1;
                func_reg        <= func;
                too_short_reg   <= too_short;
                rx_magic_reg    <= rx_magic;
                rx_session_reg  <= rx_session;
                rx_command_reg  <= rx_command;
                rx_clock_reg    <= rx_clock;
                line_is_end_reg <= line_is_end;
            end
            else if (evaluate)
            begin
                in_valid_reg <= 1'b0;
            end

            // State update and result capture.
            if (evaluate)
            begin
                mode_reg            <= mode_next;
                timer_running_reg   <= timer_running_next;
                elapsed_ticks_reg   <= elapsed_ticks_next;
                next_sequence_reg   <= next_sequence_next;
                lamport_clock_reg   <= lamport_clock_next;
                out_valid_reg       <= 1'b1;
                send_valid_reg      <= send_valid_next;
                send_command_reg    <= send_command_next;
                send_sequence_reg   <= send_sequence_next;
                send_clock_reg      <= send_clock_next;
                session_state_reg   <= mode_next;
                line_taken_reg      <= line_taken_next;
                packet_accepted_reg <= packet_accepted_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign send_valid      = send_valid_reg;
    assign send_command    = send_command_reg;
    assign send_sequence   = send_sequence_reg;
    assign send_clock      = send_clock_reg;
    assign session_state   = session_state_reg;
    assign line_taken      = line_taken_reg;
    assign packet_accepted = packet_accepted_reg;

endmodule

// ===== test/scp_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session client reply checker
// Watches the event, result and register ports of the session client block.
// For every accepted event beat it predicts the reply beat from its own copy
// of the session state and registers. It then compares each accepted result
// beat, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module scp_reply_checker
    import scp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [FUNC_W-1:0]      func,
    input  logic                   too_short,
    input  logic [MAGIC_W-1:0]     rx_magic,
    input  logic [SESSION_W-1:0]   rx_session,
    input  logic [CODE_W-1:0]      rx_command,
    input  logic [CLOCK_W-1:0]     rx_clock,
    input  logic                   line_is_end,

    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   send_valid,
    input  logic [CODE_W-1:0]      send_command,
    input  logic [SEQ_W-1:0]       send_sequence,
    input  logic [CLOCK_W-1:0]     send_clock,
    input  logic [STATE_W-1:0]     session_state,
    input  logic                   line_taken,
    input  logic                   packet_accepted,

    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output int                     mismatches,
    output int                     replies_due
);

    typedef enum logic [STATE_W-1:0] {
        M_HELLO_WAIT  = 3'd0,
        M_READY       = 3'd1,
        M_READY_TIMER = 3'd2,
        M_CLOSING     = 3'd3,
        M_CLOSED      = 3'd4
    } session_mode_t;

    typedef struct packed {
        logic                 sends;
        logic [CODE_W-1:0]    code;
        logic [SEQ_W-1:0]     seq_no;
        logic [CLOCK_W-1:0]   lamport;
        logic [STATE_W-1:0]   mode;
        logic                 taken;
        logic                 accepted;
    } reply_t;

    // Session state as the block should hold it.
    session_mode_t        mode;
    logic                 timer_on;
    logic [TICK_W-1:0]    ticks;
    logic [SEQ_W-1:0]     seq_ctr;
    logic [CLOCK_W-1:0]   lamport;

    // Register copies.
    logic [SESSION_W-1:0] reg_session;
    logic [MAGIC_W-1:0]   reg_magic;
    logic [TICK_W-1:0]    reg_timeout;
    logic [CODE_W-1:0]    hello_code;
    logic [CODE_W-1:0]    data_code;
    logic [CODE_W-1:0]    alive_code;
    logic [CODE_W-1:0]    goodbye_code;

    reply_t               staged;
    reply_t               want;
    reply_t               got;
    reply_t               due_replies[$];

    // Stamps an outgoing message: the clock moves first and its new value
    // goes out, while the sequence number goes out and then moves.
    function automatic void stamp_send(input logic [CODE_W-1:0] code);
        lamport       = lamport + 1'b1;
        staged.sends  = 1'b1;
        staged.code   = code;
        staged.seq_no = seq_ctr;
        staged.lamport = lamport;
        seq_ctr       = seq_ctr + 1'b1;
    endfunction

    function automatic void start_goodbye();
        stamp_send(goodbye_code);
        mode     = M_CLOSING;
        timer_on = 1'b1;
        ticks    = '0;
    endfunction

    // Advances the session by one event and returns the reply it causes.
    function automatic reply_t apply_event(
        input logic [FUNC_W-1:0]    f,
        input logic                 short_pkt,
        input logic [MAGIC_W-1:0]   mg,
        input logic [SESSION_W-1:0] sess,
        input logic [CODE_W-1:0]    cmd,
        input logic [CLOCK_W-1:0]   rclk,
        input logic                 last_line
    );
        staged = '0;
        if (f == FUNC_START)
        begin
            // Start only opens a closed session.
            if (mode == M_CLOSED)
            begin
                stamp_send(hello_code);
                mode     = M_HELLO_WAIT;
                timer_on = 1'b1;
                ticks    = '0;
            end
        end
        else if (mode != M_CLOSED)
        begin
            case (f)
                FUNC_PACKET:
                begin
                    if (!short_pkt && mg == reg_magic && sess == reg_session)
                    begin
                        staged.accepted = 1'b1;
                        lamport = ((lamport > rclk) ? lamport : rclk) + 1'b1;
                        // Goodbye is checked first, so it wins when codes coincide.
                        if (cmd == goodbye_code)
                        begin
                            mode     = M_CLOSED;
                            timer_on = 1'b0;
                            ticks    = '0;
                        end
                        else if (mode == M_HELLO_WAIT && cmd == hello_code)
                        begin
                            mode     = M_READY;
                            timer_on = 1'b0;
                            ticks    = '0;
                        end
                        else if (mode == M_READY_TIMER && cmd == alive_code)
                        begin
                            mode     = M_READY;
                            timer_on = 1'b0;
                            ticks    = '0;
                        end
                    end
                end
                FUNC_LINE:
                begin
                    lamport = lamport + 1'b1;
                end
                FUNC_DISPATCH:
                begin
                    // Outside the ready states the line is held.
                    if (mode == M_READY || mode == M_READY_TIMER)
                    begin
                        staged.taken = 1'b1;
                        if (last_line)
                        begin
                            start_goodbye();
                        end
                        else
                        begin
                            stamp_send(data_code);
                            mode     = M_READY_TIMER;
                            timer_on = 1'b1;
                            ticks    = '0;
                        end
                    end
                end
                FUNC_TICK:
                begin
                    if (timer_on)
                    begin
                        if (ticks != TICK_MAX)
                        begin
                            ticks = ticks + 1'b1;
                        end
                        if (ticks >= reg_timeout)
                        begin
                            timer_on = 1'b0;
                            ticks    = '0;
                            if (mode == M_CLOSING)
                            begin
                                mode = M_CLOSED;
                            end
                            else
                            begin
                                start_goodbye();
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        staged.mode = mode;
        return staged;
    endfunction

    function automatic void flag(input string what, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (mismatches < 10)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, what, exp_val, act_val);
        end
        mismatches = mismatches + 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode         = M_CLOSED;
            timer_on     = 1'b0;
            ticks        = '0;
            seq_ctr      = '0;
            lamport      = '0;
            reg_session  = '0;
            reg_magic    = '0;
            reg_timeout  = TIMEOUT_RESET;
            hello_code   = CODE_HELLO_RESET;
            data_code    = CODE_DATA_RESET;
            alive_code   = CODE_ALIVE_RESET;
            goodbye_code = CODE_GOODBYE_RESET;
            due_replies.delete();
            replies_due  = 0;
            mismatches   = 0;
        end
        else
        begin
            // Register writes only come while the block is idle.
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SESSION:      reg_session  = cfg_data[SESSION_W-1:0];
                    CFG_MAGIC:        reg_magic    = cfg_data[MAGIC_W-1:0];
                    CFG_TIMEOUT:      reg_timeout  = cfg_data[TICK_W-1:0];
                    CFG_CODE_HELLO:   hello_code   = cfg_data[CODE_W-1:0];
                    CFG_CODE_DATA:    data_code    = cfg_data[CODE_W-1:0];
                    CFG_CODE_ALIVE:   alive_code   = cfg_data[CODE_W-1:0];
                    CFG_CODE_GOODBYE: goodbye_code = cfg_data[CODE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // Result beat against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                got = {send_valid, send_command, send_sequence, send_clock,
                       session_state, line_taken, packet_accepted};
                if (due_replies.size() == 0)
                begin
                    flag("unexpected result beat", 64'd0, 64'd1);
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (got.sends !== want.sends)
                        flag("send_valid", 64'(want.sends), 64'(got.sends));
                    if (got.code !== want.code)
                        flag("send_command", 64'(want.code), 64'(got.code));
                    if (got.seq_no !== want.seq_no)
                        flag("send_sequence", 64'(want.seq_no), 64'(got.seq_no));
                    if (got.lamport !== want.lamport)
                        flag("send_clock", want.lamport, got.lamport);
                    if (got.mode !== want.mode)
                        flag("session_state", 64'(want.mode), 64'(got.mode));
                    if (got.taken !== want.taken)
                        flag("line_taken", 64'(want.taken), 64'(got.taken));
                    if (got.accepted !== want.accepted)
                        flag("packet_accepted", 64'(want.accepted), 64'(got.accepted));
                end
            end

            // Event beat: predict its reply.
            if (in_valid && !in_stall)
            begin
                due_replies.push_back(apply_event(func, too_short, rx_magic, rx_session,
                                                  rx_command, rx_clock, line_is_end));
            end
            replies_due = due_replies.size();
        end
    end

endmodule

// ===== test/tb_session_client_protocol_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session client protocol testbench
// Drives event beats into the session client block under random sender gaps
// and receiver stalls, and changes the registers between phases. A directed
// walk through the session states comes first, then random traffic under
// several register settings, a stretch of ticks under the largest timeout,
// and a final stretch at full rate. The reply checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_session_client_protocol_fsm;

    import scp_pkg::*;

    localparam int LIMIT            = 1000000;
    localparam int EVENTS_PER_PHASE = 105;
    localparam int PHASES           = 6;
    localparam int DRAIN_CYCLES     = 10;
    localparam int LONG_TICKS       = 20;

    // Event codes the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = {FUNC_W{1'b1}};

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic                 too_short;
        logic [MAGIC_W-1:0]   rx_magic;
        logic [SESSION_W-1:0] rx_session;
        logic [CODE_W-1:0]    rx_command;
        logic [CLOCK_W-1:0]   rx_clock;
        logic                 line_is_end;
    } event_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  out_stall = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    event_beat_t           beat = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic                  send_valid;
    logic [CODE_W-1:0]     send_command;
    logic [SEQ_W-1:0]      send_sequence;
    logic [CLOCK_W-1:0]    send_clock;
    logic [STATE_W-1:0]    session_state;
    logic                  line_taken;
    logic                  packet_accepted;

    int                    mismatches;
    int                    replies_due;
    int                    cycles = 0;
    bit                    idling = 1'b0;
    int                    stall_run = 0;
    bit                    stall_hold = 1'b0;

    // Register values last written, used to build matching headers.
    logic [SESSION_W-1:0]  cur_session = '0;
    logic [MAGIC_W-1:0]    cur_magic = '0;
    logic [CODE_W-1:0]     cur_hello = CODE_HELLO_RESET;
    logic [CODE_W-1:0]     cur_data = CODE_DATA_RESET;
    logic [CODE_W-1:0]     cur_alive = CODE_ALIVE_RESET;
    logic [CODE_W-1:0]     cur_goodbye = CODE_GOODBYE_RESET;

    session_client_protocol_fsm dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (beat.func),
        .too_short       (beat.too_short),
        .rx_magic        (beat.rx_magic),
        .rx_session      (beat.rx_session),
        .rx_command      (beat.rx_command),
        .rx_clock        (beat.rx_clock),
        .line_is_end     (beat.line_is_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .send_valid      (send_valid),
        .send_command    (send_command),
        .send_sequence   (send_sequence),
        .send_clock      (send_clock),
        .session_state   (session_state),
        .line_taken      (line_taken),
        .packet_accepted (packet_accepted),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    scp_reply_checker chk
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (beat.func),
        .too_short       (beat.too_short),
        .rx_magic        (beat.rx_magic),
        .rx_session      (beat.rx_session),
        .rx_command      (beat.rx_command),
        .rx_clock        (beat.rx_clock),
        .line_is_end     (beat.line_is_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .send_valid      (send_valid),
        .send_command    (send_command),
        .send_sequence   (send_sequence),
        .send_clock      (send_clock),
        .session_state   (session_state),
        .line_taken      (line_taken),
        .packet_accepted (packet_accepted),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .replies_due     (replies_due)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_session_client_protocol_fsm: FAIL");
            $finish;
        end
    end

    // Receiver: random runs of stall and flow while idling is on.
    always @(negedge clk)
    begin
        if (!idling)
        begin
            out_stall = 1'b0;
            stall_run = 0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_hold = ($urandom_range(0, 2) == 0);
                stall_run  = $urandom_range(1, 14);
            end
            out_stall = stall_hold;
            stall_run = stall_run - 1;
        end
    end

    // Random content in every field; callers then set what matters.
    function automatic event_beat_t noise();
        event_beat_t b;
        b.func        = FUNC_W'($urandom_range(0, FUNC_SPARE_LAST));
        b.too_short   = 1'($urandom_range(0, 1));
        b.rx_magic    = MAGIC_W'($urandom);
        b.rx_session  = $urandom;
        b.rx_command  = CODE_W'($urandom);
        b.rx_clock    = {$urandom, $urandom};
        b.line_is_end = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic event_beat_t plain(input logic [FUNC_W-1:0] f);
        event_beat_t b;
        b      = noise();
        b.func = f;
        return b;
    endfunction

    // A header that passes the length, magic and session checks.
    function automatic event_beat_t packet(input logic [CODE_W-1:0] cmd,
                                           input logic [CLOCK_W-1:0] rclk);
        event_beat_t b;
        b            = plain(FUNC_PACKET);
        b.too_short  = 1'b0;
        b.rx_magic   = cur_magic;
        b.rx_session = cur_session;
        b.rx_command = cmd;
        b.rx_clock   = rclk;
        return b;
    endfunction

    function automatic event_beat_t dispatch(input logic last_line);
        event_beat_t b;
        b             = plain(FUNC_DISPATCH);
        b.line_is_end = last_line;
        return b;
    endfunction

    function automatic event_beat_t random_event();
        event_beat_t b;
        int          pick;
        logic [CODE_W-1:0]  cmd;
        logic [CLOCK_W-1:0] rclk;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            b = plain(FUNC_START);
        end
        else if (pick < 45)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: cmd = cur_hello;
                3, 4:    cmd = cur_data;
                5, 6, 7: cmd = cur_alive;
                8:       cmd = cur_goodbye;
                default: cmd = CODE_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       rclk = CLOCK_W'($urandom_range(0, 300));
                1:       rclk = {$urandom, $urandom};
                2:       rclk = {CLOCK_W{1'b1}} - CLOCK_W'($urandom_range(0, 3));
                default: rclk = '0;
            endcase
            b = packet(cmd, rclk);
            // Some headers are broken in one way.
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       b.too_short = 1'b1;
                    1:       b.rx_magic = b.rx_magic ^ (16'd1 << $urandom_range(0, 15));
                    default: b.rx_session = b.rx_session ^ (32'd1 << $urandom_range(0, 31));
                endcase
            end
        end
        else if (pick < 55)
        begin
            b = plain(FUNC_LINE);
        end
        else if (pick < 78)
        begin
            b = dispatch($urandom_range(0, 6) == 0);
        end
        else if (pick < 97)
        begin
            b = plain(FUNC_TICK);
        end
        else
        begin
            b = plain(FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)));
        end
        return b;
    endfunction

    // Offers one event beat and returns once it has been accepted.
    task automatic offer(input event_beat_t b);
        int gap;
        gap = 0;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        beat     = b;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Stops sending and waits until every predicted reply has come back.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (replies_due != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
    endtask

    task automatic configure(input logic [SESSION_W-1:0] s, input logic [MAGIC_W-1:0] m,
                             input logic [TICK_W-1:0] t, input logic [CODE_W-1:0] h,
                             input logic [CODE_W-1:0] d, input logic [CODE_W-1:0] a,
                             input logic [CODE_W-1:0] g);
        settle();
        put_reg(CFG_SESSION, s);
        put_reg(CFG_MAGIC, CFG_DATA_W'(m));
        put_reg(CFG_TIMEOUT, CFG_DATA_W'(t));
        put_reg(CFG_CODE_HELLO, CFG_DATA_W'(h));
        put_reg(CFG_CODE_DATA, CFG_DATA_W'(d));
        put_reg(CFG_CODE_ALIVE, CFG_DATA_W'(a));
        put_reg(CFG_CODE_GOODBYE, CFG_DATA_W'(g));
        @(negedge clk);
        cfg_write   = 1'b0;
        cur_session = s;
        cur_magic   = m;
        cur_hello   = h;
        cur_data    = d;
        cur_alive   = a;
        cur_goodbye = g;
    endtask

    initial
    begin
        event_beat_t     b;
        logic [CODE_W-1:0] same_code;
        int              p;
        int              n;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n  = 1'b1;
        idling = 1'b1;

        // Directed walk under the reset register values.
        // Events other than start are ignored while closed.
        offer(plain(FUNC_TICK));
        offer(dispatch(1'b0));
        offer(plain(FUNC_SPARE_FIRST));
        offer(plain(FUNC_SPARE_LAST));
        offer(plain(FUNC_START));
        // A second start is ignored; a dispatch while waiting is held.
        offer(plain(FUNC_START));
        offer(dispatch(1'b0));
        offer(plain(FUNC_LINE));
        // Dropped headers: short, wrong magic, wrong session.
        b = packet(cur_hello, 64'd7);
        b.too_short = 1'b1;
        offer(b);
        b = packet(cur_hello, 64'd7);
        b.rx_magic = ~cur_magic;
        offer(b);
        b = packet(cur_hello, 64'd7);
        b.rx_session = ~cur_session;
        offer(b);
        // An accepted header of another kind only moves the clock.
        offer(packet(cur_data, 64'd40));
        // Hello at the top clock value makes the clock wrap to zero.
        offer(packet(cur_hello, {CLOCK_W{1'b1}}));
        offer(dispatch(1'b0));
        offer(packet(cur_alive, 64'd0));
        // Data then silence: a timeout sends goodbye, a second one closes.
        offer(dispatch(1'b0));
        repeat (2 * TIMEOUT_RESET) offer(plain(FUNC_TICK));
        // End of input closes through goodbye, and the peer's goodbye ends it.
        offer(plain(FUNC_START));
        offer(packet(cur_hello, 64'd0));
        offer(dispatch(1'b1));
        offer(packet(cur_goodbye, 64'd3));

        // Random traffic under a series of register settings.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    configure({SESSION_W{1'b1}}, {MAGIC_W{1'b1}}, 16'd1,
                              8'hFF, 8'h00, 8'h80, 8'h7F);
                end
                1:
                begin
                    configure($urandom, MAGIC_W'($urandom), 16'd0,
                              CODE_W'($urandom), CODE_W'($urandom),
                              CODE_W'($urandom), CODE_W'($urandom));
                end
                2:
                begin
                    same_code = CODE_W'($urandom);
                    configure($urandom, MAGIC_W'($urandom), 16'd3,
                              same_code, same_code, same_code, same_code);
                end
                default:
                begin
                    configure($urandom, MAGIC_W'($urandom), TICK_W'($urandom_range(1, 8)),
                              CODE_W'($urandom), CODE_W'($urandom),
                              CODE_W'($urandom), CODE_W'($urandom));
                end
            endcase

            // Before the last phase, tick a while under the largest timeout.
            if (p == PHASES - 1)
            begin
                idling = 1'b0;
                configure(cur_session, cur_magic, {TICK_W{1'b1}},
                          cur_hello, cur_data, cur_alive, cur_goodbye);
                offer(packet(cur_goodbye, 64'd0));
                offer(plain(FUNC_START));
                repeat (LONG_TICKS) offer(plain(FUNC_TICK));
                offer(packet(cur_goodbye, 64'd0));
                configure($urandom, MAGIC_W'($urandom), TICK_W'($urandom_range(1, 8)),
                          CODE_W'($urandom), CODE_W'($urandom),
                          CODE_W'($urandom), CODE_W'($urandom));
            end

            for (n = 0; n < EVENTS_PER_PHASE; n++)
            begin
                // Idling comes and goes in stretches; the last phase runs flat out.
                if (n % 40 == 0)
                begin
                    idling = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
                end
                offer(random_event());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && replies_due == 0)
        begin
            $display("tb_session_client_protocol_fsm: PASS");
        end
        else
        begin
            $display("tb_session_client_protocol_fsm: FAIL");
        end
        $finish;
    end

endmodule

// ===== session_client_protocol_fsm.f =====
rtl/scp_pkg.sv
rtl/session_client_protocol_fsm.sv
test/scp_reply_checker.sv
test/tb_session_client_protocol_fsm.sv
